@@ src/speak_gate_rate_policy_unit_defines.svh @@
// Assertion macros shared by the speak gate rate policy unit.
`ifndef SPEAK_GATE_RATE_POLICY_UNIT_DEFINES_SVH
`define SPEAK_GATE_RATE_POLICY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define SGRP_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgrp assertion failed");
// next-cycle implication, disabled in reset
`define SGRP_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgrp assertion failed");
`else
`define SGRP_ASSERT_IMP(name, clk, rst, ante, cons)
`define SGRP_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

@@ src/sgrp_pkg.sv @@
// Types, codes and constants of the speak gate rate policy unit.
package sgrp_pkg;

  localparam int unsigned WINDOW_SECONDS = 3600;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] WIN_MAX = 16'hFFFF;
  localparam logic [31:0] WINDOW_LEN = 32'(WINDOW_SECONDS);

  typedef enum logic [2:0] {
    OP_EVALUATE   = 3'd0,
    OP_SPOKEN     = 3'd1,
    OP_ACCEPTED   = 3'd2,
    OP_DISMISSED  = 3'd3,
    OP_SUPPRESSED = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    VD_SPEAK        = 4'd0,
    VD_DISABLED     = 4'd1,
    VD_LOW_CONF     = 4'd2,
    VD_EXCLUDED     = 4'd3,
    VD_FULL_SCREEN  = 4'd4,
    VD_BUSY         = 4'd5,
    VD_DISMISS_CD   = 4'd6,
    VD_COOLDOWN     = 4'd7,
    VD_BUDGET       = 4'd8,
    VD_REDUCED      = 4'd9
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE_BITS      = 3'd0,
    REG_MIN_CONFIDENCE = 3'd1,
    REG_QUIET_INPUT    = 3'd2,
    REG_DISMISS_CD     = 3'd3,
    REG_COOLDOWN       = 3'd4,
    REG_MAX_PER_HOUR   = 3'd5,
    REG_MIN_PRECISION  = 3'd6,
    REG_SAMPLE_FLOOR   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  mode_bits;
    logic [15:0] min_confidence;
    logic [15:0] quiet_input_seconds;
    logic [15:0] dismissal_cooldown_seconds;
    logic [15:0] cooldown_seconds;
    logic [7:0]  max_per_hour;
    logic [15:0] min_precision;
    logic [15:0] precision_sample_floor;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode_bits:                  2'd3,
    min_confidence:             16'd45875,
    quiet_input_seconds:        16'd30,
    dismissal_cooldown_seconds: 16'd1800,
    cooldown_seconds:           16'd300,
    max_per_hour:               8'd4,
    min_precision:              16'd32768,
    precision_sample_floor:     16'd5
  };

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] time_now;
    logic [15:0] confidence;
    logic [15:0] idle_seconds;
    logic        source_excluded;
    logic        source_full_screen;
  } item_t;

  typedef struct packed {
    logic        has_spoken;
    logic        has_dismissal;
    logic [31:0] last_spoken_time;
    logic [31:0] last_dismissed_time;
    logic [31:0] window_start_time;
    logic [15:0] spoken_in_window;
    logic [31:0] spoken_count;
    logic [31:0] accepted_count;
    logic [31:0] dismissed_count;
    logic [31:0] suppressed_count;
  } st_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] spoken_total;
    logic [31:0] accepted_total;
    logic [31:0] dismissed_total;
    logic [31:0] suppressed_total;
  } res_t;

endpackage

@@ src/sgrp_channels.sv @@
// Item and result channel interfaces of the speak gate rate policy unit.
interface sgrp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] time_now;
  logic [15:0] confidence;
  logic [15:0] idle_seconds;
  logic        source_excluded;
  logic        source_full_screen;

  modport source (output valid, operation, time_now, confidence, idle_seconds,
                  source_excluded, source_full_screen, input ready);
  modport sink (input valid, operation, time_now, confidence, idle_seconds,
                source_excluded, source_full_screen, output ready);
endinterface

interface sgrp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic        rate_reduced;
  logic [31:0] spoken_total;
  logic [31:0] accepted_total;
  logic [31:0] dismissed_total;
  logic [31:0] suppressed_total;

  modport source (output valid, verdict, rate_reduced, spoken_total, accepted_total,
                  dismissed_total, suppressed_total, input ready);
  modport sink (input valid, verdict, rate_reduced, spoken_total, accepted_total,
                dismissed_total, suppressed_total, output ready);
endinterface

@@ src/sgrp_cfg_regs.sv @@
// Configuration register file with a plain write port.
module sgrp_cfg_regs import sgrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg,
  output logic [15:0]           min_precision_next
);

  cfg_t cfg_next;

  // write decode
  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (cfg_idx_e'(wr_index))
        REG_MODE_BITS:      cfg_next.mode_bits = wr_data[1:0];
        REG_MIN_CONFIDENCE: cfg_next.min_confidence = wr_data;
        REG_QUIET_INPUT:    cfg_next.quiet_input_seconds = wr_data;
        REG_DISMISS_CD:     cfg_next.dismissal_cooldown_seconds = wr_data;
        REG_COOLDOWN:       cfg_next.cooldown_seconds = wr_data;
        REG_MAX_PER_HOUR:   cfg_next.max_per_hour = wr_data[7:0];
        REG_MIN_PRECISION:  cfg_next.min_precision = wr_data;
        REG_SAMPLE_FLOOR:   cfg_next.precision_sample_floor = wr_data;
        default:            cfg_next = cfg;
      endcase
    end
  end

  assign min_precision_next = cfg_next.min_precision;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

@@ src/sgrp_state.sv @@
// Event state, saturating counters and the registered precision product.
module sgrp_state import sgrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        upd,
  input  item_t       item,
  input  cfg_t        cfg,
  input  logic [15:0] min_precision_next,
  output st_t         st,
  output st_t         st_next,
  output logic        reduced
);

  logic [31:0] win_elapsed;
  logic        win_restart;
  logic [15:0] win_base;
  logic [32:0] judged;
  logic [32:0] judged_next;
  logic        judged_inc;
  logic [48:0] prod;
  logic [48:0] prod_next;
  logic [15:0] floor_eff;

  assign win_elapsed = item.time_now - st.window_start_time;
  assign win_restart = !st.has_spoken || (win_elapsed >= WINDOW_LEN);
  assign win_base    = win_restart ? 16'd0 : st.spoken_in_window;

  // record updates
  always_comb begin
    st_next = st;
    if (upd) begin
      case (op_e'(item.operation))
        OP_SPOKEN: begin
          if (win_restart) st_next.window_start_time = item.time_now;
          st_next.spoken_in_window = (win_base != WIN_MAX) ? win_base + 16'd1 : win_base;
          if (st.spoken_count != CNT_MAX) st_next.spoken_count = st.spoken_count + 32'd1;
          st_next.last_spoken_time = item.time_now;
          st_next.has_spoken       = 1'b1;
        end
        OP_ACCEPTED: begin
          if (st.accepted_count != CNT_MAX) st_next.accepted_count = st.accepted_count + 32'd1;
        end
        OP_DISMISSED: begin
          if (st.dismissed_count != CNT_MAX) begin
            st_next.dismissed_count = st.dismissed_count + 32'd1;
          end
          st_next.last_dismissed_time = item.time_now;
          st_next.has_dismissal       = 1'b1;
        end
        OP_SUPPRESSED: begin
          if (st.suppressed_count != CNT_MAX) begin
            st_next.suppressed_count = st.suppressed_count + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // judged count tracks accepted + dismissed; product follows it and min_precision
  assign judged_inc  = (st_next.accepted_count != st.accepted_count) ||
                       (st_next.dismissed_count != st.dismissed_count);
  assign judged_next = judged + {32'd0, judged_inc};
  assign prod_next   = {33'd0, min_precision_next} * {16'd0, judged_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '0;
      judged <= '0;
      prod   <= '0;
    end else begin
      st     <= st_next;
      judged <= judged_next;
      prod   <= prod_next;
    end
  end

  // low precision: enough judged events and accepted/judged below threshold
  assign floor_eff = (cfg.precision_sample_floor == 16'd0) ? 16'd1
                                                           : cfg.precision_sample_floor;
  assign reduced   = (judged >= {17'd0, floor_eff}) &&
                     ({1'b0, st.accepted_count, 16'd0} < prod);

endmodule

@@ src/sgrp_eval.sv @@
// Verdict chain for an evaluate item against the current state.
module sgrp_eval import sgrp_pkg::*; (
  input  item_t    item,
  input  cfg_t     cfg,
  input  st_t      st,
  input  logic     reduced,
  output verdict_e verdict
);

  logic [31:0] since_dismiss;
  logic [31:0] since_spoken;
  logic [31:0] since_window;
  logic [7:0]  budget_half;
  logic [7:0]  budget;
  logic [15:0] used;

  assign since_dismiss = item.time_now - st.last_dismissed_time;
  assign since_spoken  = item.time_now - st.last_spoken_time;
  assign since_window  = item.time_now - st.window_start_time;

  // halved budget keeps a floor of one
  assign budget_half = (cfg.max_per_hour[7:1] == 7'd0) ? 8'd1 : {1'b0, cfg.max_per_hour[7:1]};
  assign budget      = reduced ? budget_half : cfg.max_per_hour;
  assign used        = (st.has_spoken && (since_window < WINDOW_LEN)) ? st.spoken_in_window
                                                                       : 16'd0;

  // checks in fixed priority order
  always_comb begin
    verdict = VD_SPEAK;
    if (op_e'(item.operation) == OP_EVALUATE) begin
      if (!cfg.mode_bits[0]) begin
        verdict = VD_DISABLED;
      end else if (item.confidence < cfg.min_confidence) begin
        verdict = VD_LOW_CONF;
      end else if (item.source_excluded) begin
        verdict = VD_EXCLUDED;
      end else if (cfg.mode_bits[1] && item.source_full_screen) begin
        verdict = VD_FULL_SCREEN;
      end else if (item.idle_seconds < cfg.quiet_input_seconds) begin
        verdict = VD_BUSY;
      end else if (st.has_dismissal &&
                   (since_dismiss < {16'd0, cfg.dismissal_cooldown_seconds})) begin
        verdict = VD_DISMISS_CD;
      end else if (st.has_spoken && (since_spoken < {16'd0, cfg.cooldown_seconds})) begin
        verdict = VD_COOLDOWN;
      end else if (used >= {8'd0, budget}) begin
        verdict = reduced ? VD_REDUCED : VD_BUDGET;
      end
    end
  end

endmodule

@@ src/speak_gate_rate_policy_unit.sv @@
// Top level of the speak gate rate policy unit: three-stage item pipeline.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    operation, time_now, confidence, idle_seconds, flags
//   out_ch    out   valid/ready    verdict, rate_reduced, four event totals
//   wr_*      in    wr_en only     wr_index, wr_data
//
// One item per cycle while out_ch does not stall; a result is offered on out_ch after
// its transfer in (input register at the transfer edge, then result and output
// registers). The state update lands as an item leaves the input register, and the
// output register samples rate_reduced from the precision product registered with it.
// Each stage holds while the next is full and stalled, so an item is still taken
// while a result waits if a stage is free; rst clears state and counters, presets cfg.
`include "speak_gate_rate_policy_unit_defines.svh"

module speak_gate_rate_policy_unit import sgrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  sgrp_in_if.sink               in_ch,
  sgrp_out_if.source            out_ch
);

  cfg_t        cfg;
  logic [15:0] min_precision_next;
  st_t         st;
  st_t         st_next;
  logic        reduced;
  verdict_e    verdict;

  item_t       item;
  logic        v1;
  res_t        res;
  logic        v2;
  res_t        outr;
  logic        out_reduced;
  logic        v3;

  logic        ready1;
  logic        ready2;
  logic        ready3;
  logic        upd;
  logic        out_judged;

  sgrp_cfg_regs u_cfg (
    .clk                (clk),
    .rst                (rst),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data),
    .cfg                (cfg),
    .min_precision_next (min_precision_next)
  );

  sgrp_state u_state (
    .clk                (clk),
    .rst                (rst),
    .upd                (upd),
    .item               (item),
    .cfg                (cfg),
    .min_precision_next (min_precision_next),
    .st                 (st),
    .st_next            (st_next),
    .reduced            (reduced)
  );

  sgrp_eval u_eval (
    .item    (item),
    .cfg     (cfg),
    .st      (st),
    .reduced (reduced),
    .verdict (verdict)
  );

  // per-stage flow control
  assign ready3 = !v3 || out_ch.ready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign upd    = v1 && ready2;

  assign in_ch.ready = ready1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_ch.valid) begin
      item.operation          <= in_ch.operation;
      item.time_now           <= in_ch.time_now;
      item.confidence         <= in_ch.confidence;
      item.idle_seconds       <= in_ch.idle_seconds;
      item.source_excluded    <= in_ch.source_excluded;
      item.source_full_screen <= in_ch.source_full_screen;
    end
  end

  // result register: verdict and totals after this item's update
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res.verdict          <= verdict;
      res.spoken_total     <= st_next.spoken_count;
      res.accepted_total   <= st_next.accepted_count;
      res.dismissed_total  <= st_next.dismissed_count;
      res.suppressed_total <= st_next.suppressed_count;
    end
  end

  // output register: adds rate_reduced of the updated state
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      outr        <= res;
      out_reduced <= reduced;
    end
  end

  assign out_ch.valid            = v3;
  assign out_ch.verdict          = outr.verdict;
  assign out_ch.rate_reduced     = out_reduced;
  assign out_ch.spoken_total     = outr.spoken_total;
  assign out_ch.accepted_total   = outr.accepted_total;
  assign out_ch.dismissed_total  = outr.dismissed_total;
  assign out_ch.suppressed_total = outr.suppressed_total;

  assign out_judged = (outr.accepted_total != 32'd0) || (outr.dismissed_total != 32'd0);

  // state moves only when an item leaves the input register
  `SGRP_ASSERT_NXT(a_cnt_hold, clk, rst, !upd, $stable(st))
  // reduced rate needs at least one judged event
  `SGRP_ASSERT_IMP(a_reduced_judged, clk, rst, v3 && out_reduced, out_judged)
  // a full input register that cannot drain means the result stage is blocked
  `SGRP_ASSERT_IMP(a_stall_chain, clk, rst, v1 && !in_ch.ready, v2 && v3 && !out_ch.ready)

endmodule
